>>> design/npcm_pkg.sv
// npcm_pkg: shared constants, codes and types of the nearest point color map.
// No dependencies; npcm_if, npcm_dist and the top level import it.
package npcm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COORD_BITS = 16;
    localparam int COUNT_W    = 11;
    localparam int INDEX_FW   = 10;
    localparam int COLOR_W    = 32;
    localparam int DIST_W     = 2 * COORD_BITS + 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_pos;

    // candidate travelling down the distance pipeline
    typedef struct packed {
        logic               vld;
        logic               first;
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
    } t_tag;

endpackage

>>> design/npcm_if.sv
// npcm_in_if / npcm_out_if: valid/ready channels of the nearest point color map.
// Depends on npcm_pkg for the field widths.
interface npcm_in_if import npcm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [INDEX_FW-1:0]          entry_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [COLOR_W-1:0]           color_word;

    modport source (output valid, action, entry_index, pos_x, pos_y, pos_z, color_word,
                    input ready);
    modport sink   (input valid, action, entry_index, pos_x, pos_y, pos_z, color_word,
                    output ready);
endinterface

interface npcm_out_if import npcm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [INDEX_FW-1:0] nearest_index;
    logic [COLOR_W-1:0]  nearest_color;
    logic [DIST_W-1:0]   squared_distance;

    modport source (output valid, nearest_index, nearest_color, squared_distance,
                    input ready);
    modport sink   (input valid, nearest_index, nearest_color, squared_distance,
                    output ready);
endinterface

>>> design/npcm_ram.sv
// npcm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module npcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/npcm_dist.sv
// npcm_dist: three-stage squared distance pipeline (abs diff, square, sum).
// Depends on npcm_pkg.
module npcm_dist import npcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  t_pos              i_pt,
    input  t_pos              i_query,
    output t_tag              o_tag,
    output logic [DIST_W-1:0] o_dist
);

    localparam int CB = COORD_BITS;

    function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
        logic [CB:0] d;
        logic [CB:0] mag;
        d   = {a[CB-1], a} - {b[CB-1], b};
        mag = d[CB] ? (~d + 1'b1) : d;
        return mag[CB-1:0];
    endfunction

    logic [CB-1:0]     r_ab [3];
    logic [2*CB-1:0]   r_sq [3];
    logic [DIST_W-1:0] r_dist;
    t_tag              r_tag1, r_tag2, r_tag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ab[0] <= abs_diff(i_query.x, i_pt.x);
        r_ab[1] <= abs_diff(i_query.y, i_pt.y);
        r_ab[2] <= abs_diff(i_query.z, i_pt.z);
        r_sq[0] <= r_ab[0] * r_ab[0];
        r_sq[1] <= r_ab[1] * r_ab[1];
        r_sq[2] <= r_ab[2] * r_ab[2];
        r_dist  <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    end

    assign o_tag  = r_tag3;
    assign o_dist = r_dist;

endmodule

>>> design/nearest_point_color_map.sv
// nearest_point_color_map: top level, table memories, scan control, best tracking.
// Depends on npcm_pkg, npcm_if, npcm_ram and npcm_dist.
//
// Input channel i_in carries one transaction per item. action = write stores
// position and color at entry_index; the next item may follow in the next
// cycle. action = query scans entries 0 .. point_count-1 (0 acts as 1, values
// above the table size saturate) and returns on o_out the index, color and
// squared distance of the closest entry, lowest index on a tie.
// A query occupies the block from acceptance until the result is loaded into the
// output register: one entry is read per cycle from the single read port of the
// table memories, followed by a three-stage distance pipeline and a compare stage.
// i_in.ready is low during that time. The output register holds one finished
// result; while it waits, writes and the next query are still accepted. If a
// second result is finished before the receiver takes the first, it waits in the
// block until o_out drains. point_count is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while idle, as the block does not
// enforce this. Reset (synchronous, active low) sets point_count to 1 and empties
// the output; table contents are undefined until written.
module nearest_point_color_map import npcm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [COUNT_W-1:0] i_cfg_wr_data,
    npcm_in_if.sink            i_in,
    npcm_out_if.source         o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [IDX_W-1:0]   r_rd_addr, n_rd_addr;
    logic [IDX_W-1:0]   r_last, n_last;
    logic               r_done, n_done;
    t_pos               r_query;
    t_tag               r_iss_tag, n_iss_tag;

    logic [DIST_W-1:0]  r_best_d, n_best_d;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [COLOR_W-1:0] r_best_color, n_best_color;

    logic               r_out_valid;
    logic [INDEX_FW-1:0] r_out_idx;
    logic [COLOR_W-1:0] r_out_color;
    logic [DIST_W-1:0]  r_out_dist;

    logic               in_acc, wr_en, query_start, rd_en, out_free, load;
    logic [COUNT_W-1:0] last_cnt;
    t_pos               wr_pos, rd_pos;
    logic [$bits(t_pos)-1:0] rd_pos_vec;
    logic [COLOR_W-1:0] rd_color;
    t_tag               dist_in_tag, dist_tag;
    logic [DIST_W-1:0]  dist_d;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign wr_en       = in_acc && (i_in.action == ACT_WRITE)
                         && (int'(i_in.entry_index) < MAX_POINTS);
    assign query_start = in_acc && (i_in.action == ACT_QUERY);
    assign rd_en       = (r_state == ST_SCAN);
    assign out_free    = !r_out_valid || o_out.ready;
    assign load        = (r_state == ST_FINISH) && r_done && out_free;

    assign wr_pos.x = i_in.pos_x;
    assign wr_pos.y = i_in.pos_y;
    assign wr_pos.z = i_in.pos_z;

    // index of the last entry searched
    always_comb begin
        if (r_count == '0) begin
            last_cnt = '0;
        end else if (r_count > COUNT_W'(MAX_POINTS)) begin
            last_cnt = COUNT_W'(MAX_POINTS - 1);
        end else begin
            last_cnt = r_count - 1'b1;
        end
    end

    npcm_ram #(.WIDTH($bits(t_pos)), .DEPTH(MAX_POINTS)) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_in.entry_index)),
        .i_wr_data (wr_pos),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_pos_vec)
    );

    npcm_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_POINTS)) u_color_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_in.entry_index)),
        .i_wr_data (i_in.color_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_color)
    );

    assign rd_pos = t_pos'(rd_pos_vec);

    // read data arrives the cycle after the address; r_iss_tag lines up with it
    always_comb begin
        dist_in_tag       = r_iss_tag;
        dist_in_tag.color = rd_color;
    end

    npcm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (dist_in_tag),
        .i_pt    (rd_pos),
        .i_query (r_query),
        .o_tag   (dist_tag),
        .o_dist  (dist_d)
    );

    always_comb begin
        n_state   = r_state;
        n_rd_addr = r_rd_addr;
        n_last    = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (query_start) begin
                    n_state   = ST_SCAN;
                    n_rd_addr = '0;
                    n_last    = last_cnt[IDX_W-1:0];
                end
            end
            ST_SCAN: begin
                if (r_rd_addr == r_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_rd_addr = r_rd_addr + 1'b1;
                end
            end
            ST_FINISH: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_iss_tag       = '0;
        n_iss_tag.vld   = rd_en;
        n_iss_tag.first = (r_rd_addr == '0);
        n_iss_tag.last  = (r_rd_addr == r_last);
        n_iss_tag.idx   = r_rd_addr;
    end

    // strict less-than keeps the lowest index on a tie
    always_comb begin
        n_best_d     = r_best_d;
        n_best_idx   = r_best_idx;
        n_best_color = r_best_color;
        if (dist_tag.vld && (dist_tag.first || (dist_d < r_best_d))) begin
            n_best_d     = dist_d;
            n_best_idx   = dist_tag.idx;
            n_best_color = dist_tag.color;
        end
        n_done = r_done;
        if (query_start) begin
            n_done = 1'b0;
        end else if (dist_tag.vld && dist_tag.last) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= COUNT_W'(1);
            r_rd_addr   <= '0;
            r_last      <= '0;
            r_done      <= 1'b0;
            r_iss_tag   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_addr <= n_rd_addr;
            r_last    <= n_last;
            r_done    <= n_done;
            r_iss_tag <= n_iss_tag;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_d     <= n_best_d;
        r_best_idx   <= n_best_idx;
        r_best_color <= n_best_color;
        if (query_start) begin
            r_query <= wr_pos;
        end
        if (load) begin
            r_out_idx   <= INDEX_FW'(r_best_idx);
            r_out_color <= r_best_color;
            r_out_dist  <= r_best_d;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.nearest_index    = r_out_idx;
    assign o_out.nearest_color    = r_out_color;
    assign o_out.squared_distance = r_out_dist;

endmodule
